FILE: hdl/rbp_pkg.sv
// Shared types and constants for the Rice encoder bit packer.
package rbp_pkg;

  localparam int KW   = 5;
  localparam int VW   = 32;
  localparam int BW   = 8;
  localparam int CAPW = 32;

  typedef enum logic [1:0] {
    REQ_ENCODE  = 2'd0,
    REQ_FLUSH   = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CAP  = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    restart;
    logic    uchunk;
    logic    rchunk;
    logic    flush;
    logic    push_hold;
    logic    hold_last;
    logic    push_close;
    status_t close_status;
  } cmd_t;

  typedef struct packed {
    logic q_over;
    logic u_done;
    logic r_done;
    logic u_room;
    logic r_room;
    logic pend_any;
    logic hold_valid;
    logic go;
  } sts_t;

endpackage

FILE: hdl/rbp_in_if.sv
// Input item channel: request type and value.
interface rbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

FILE: hdl/rbp_out_if.sv
// Result item channel: packed byte, byte flag, status and last flag.
interface rbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_byte, byte_valid, status, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

FILE: hdl/rbp_regs.sv
// APB-style configuration registers: Rice parameter and byte capacity.
module rbp_regs
  import rbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready,
  output logic [KW-1:0]   rice_k,
  output logic [CAPW-1:0] capacity
);

  logic [KW-1:0]   rice_k_r;
  logic [CAPW-1:0] cap_r;
  logic            wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rice_k_r <= '0;
      cap_r    <= '1;
    end else if (wr_en) begin
      if (cfg_paddr[2]) begin
        cap_r <= cfg_pwdata;
      end else begin
        rice_k_r <= cfg_pwdata[KW-1:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? cap_r : {{(32-KW){1'b0}}, rice_k_r};
  assign rice_k     = rice_k_r;
  assign capacity   = cap_r;

endmodule

FILE: hdl/rbp_ctrl.sv
// Controller: sequences encode, flush and restart items over the datapath.
module rbp_ctrl
  import rbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rbp_in_if.sink in_ch,
  input  sts_t  sts,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNARY,
    S_REM,
    S_FLUSH,
    S_FIN,
    S_CLOSE
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    accept;
  req_t    req;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign req         = req_t'(in_ch.req_type);

  always_comb begin
    cmd          = '0;
    cmd.close_status = st_r;
    state_nxt    = state_r;
    st_nxt       = st_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          st_nxt   = ST_OK;
          case (req)
            REQ_ENCODE: state_nxt = S_UNARY;
            REQ_FLUSH:  state_nxt = S_FLUSH;
            REQ_RESTART: begin
              cmd.restart = 1'b1;
              state_nxt   = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_UNARY: begin
        if (sts.q_over) begin
          st_nxt    = ST_OVER;
          state_nxt = S_FIN;
        end else if (sts.u_done) begin
          if (sts.r_done) begin
            state_nxt = S_FIN;
          end else if (!sts.r_room) begin
            st_nxt    = ST_CAP;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_REM;
          end
        end else if (!sts.u_room) begin
          st_nxt    = ST_CAP;
          state_nxt = S_FIN;
        end else if (sts.go) begin
          cmd.uchunk = 1'b1;
        end
      end
      S_REM: begin
        if (sts.r_done) begin
          state_nxt = S_FIN;
        end else if (sts.go) begin
          cmd.rchunk = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.pend_any && !sts.u_room) begin
          st_nxt = ST_CAP;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.go) begin
          if (sts.hold_valid) begin
            cmd.push_hold = 1'b1;
            cmd.hold_last = (st_r == ST_OK);
            state_nxt     = (st_r == ST_OK) ? S_IDLE : S_CLOSE;
          end else begin
            cmd.push_close = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (sts.go) begin
          cmd.push_close = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  a_over_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNARY && sts.q_over) |=> (state_r == S_FIN && st_r == ST_OVER))
    else $error("quotient over limit did not close the item");

  a_fail_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && sts.go && sts.hold_valid && st_r != ST_OK) |=>
    (state_r == S_CLOSE))
    else $error("failed item lost its closing result");

endmodule

FILE: hdl/rbp_dp.sv
// Datapath: Rice code bit packing, capacity checks, held byte and output register.
module rbp_dp
  import rbp_pkg::*;
#(
  parameter int MAX_QUOTIENT = 255
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic [VW-1:0]   value,
  input  logic [KW-1:0]   rice_k,
  input  logic [CAPW-1:0] capacity,
  rbp_out_if.source       out_ch
);

  localparam int UW = $clog2(MAX_QUOTIENT + 2);
  localparam int CW = (UW > 4) ? UW : 4;

  logic [UW-1:0]   ucnt_r;
  logic [KW-1:0]   rcnt_r;
  logic [VW-1:0]   rem_r;
  logic            q_over_r;
  logic [BW-1:0]   pb_r;
  logic [2:0]      pc_r;
  logic [CAPW-1:0] be_r;
  logic [BW-1:0]   hold_r;
  logic            hold_valid_r;
  logic            out_valid_r;
  logic [BW-1:0]   out_byte_r;
  logic            out_bv_r;
  logic [1:0]      out_status_r;
  logic            out_last_r;

  logic [VW-1:0]   q;
  logic [3:0]      space, un, rn, n, sum;
  logic [CW-1:0]   ucnt_w, space_w;
  logic            u_last;
  logic [BW-1:0]   mask, low, ubits, rbits, cbits, merged, new_byte;
  logic            chunk, chunk_full, room1, flush_emit, byte_done, push_any;
  logic [5:0]      extra_sum;
  logic [CAPW:0]   need;
  logic            go;

  assign q       = value >> rice_k;
  assign space   = 4'd8 - {1'b0, pc_r};
  assign ucnt_w  = CW'(ucnt_r);
  assign space_w = CW'(space);
  assign un      = (ucnt_w < space_w) ? ucnt_w[3:0] : space;
  assign u_last  = (ucnt_w <= space_w);
  assign rn      = (rcnt_r < {1'b0, space}) ? rcnt_r[3:0] : space;
  assign n       = cmd.uchunk ? un : rn;
  assign sum     = {1'b0, pc_r} + n;
  assign mask    = (8'hFF >> pc_r) & ~(8'hFF >> sum);
  assign low     = mask & (~mask + 8'd1);
  assign ubits   = u_last ? (mask & ~low) : mask;
  assign rbits   = (rem_r[VW-1 -: BW] >> pc_r) & mask;
  assign cbits   = cmd.uchunk ? ubits : rbits;
  assign merged  = pb_r | cbits;

  assign chunk      = cmd.uchunk || cmd.rchunk;
  assign chunk_full = chunk && sum[3];
  assign room1      = (be_r < capacity);
  assign flush_emit = cmd.flush && (pc_r != 3'd0) && room1;
  assign byte_done  = chunk_full || flush_emit;
  assign new_byte   = chunk ? merged : pb_r;

  assign extra_sum = 6'(pc_r) + 6'(rcnt_r) + 6'd7;
  assign need      = {1'b0, be_r} + (CAPW + 1)'(extra_sum[5:3]);

  assign go       = !out_valid_r || out_ch.ready;
  assign push_any = cmd.push_close || cmd.push_hold || (byte_done && hold_valid_r);

  assign sts.q_over     = q_over_r;
  assign sts.u_done     = (ucnt_r == '0);
  assign sts.r_done     = (rcnt_r == '0);
  assign sts.u_room     = room1;
  assign sts.r_room     = (need <= {1'b0, capacity});
  assign sts.pend_any   = (pc_r != 3'd0);
  assign sts.hold_valid = hold_valid_r;
  assign sts.go         = go;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_over_r <= (q > VW'(MAX_QUOTIENT));
      ucnt_r   <= UW'(q) + UW'(1);
      rcnt_r   <= rice_k;
      rem_r    <= value << (KW'(0) - rice_k);
    end else if (cmd.uchunk) begin
      ucnt_r <= ucnt_r - UW'(un);
    end else if (cmd.rchunk) begin
      rcnt_r <= rcnt_r - KW'(rn);
      rem_r  <= rem_r << rn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= '0;
      pc_r <= '0;
      be_r <= '0;
    end else if (cmd.restart) begin
      pb_r <= '0;
      pc_r <= '0;
      be_r <= '0;
    end else if (cmd.flush) begin
      pb_r <= '0;
      pc_r <= '0;
      if (flush_emit) begin
        be_r <= be_r + 1'b1;
      end
    end else if (chunk) begin
      if (chunk_full) begin
        pb_r <= '0;
        pc_r <= '0;
        be_r <= be_r + 1'b1;
      end else begin
        pb_r <= merged;
        pc_r <= sum[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (byte_done) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.push_hold) begin
        hold_valid_r <= 1'b0;
      end
      if (push_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_done) begin
      hold_r <= new_byte;
    end
    if (cmd.push_close) begin
      out_byte_r   <= '0;
      out_bv_r     <= 1'b0;
      out_status_r <= cmd.close_status;
      out_last_r   <= 1'b1;
    end else if (cmd.push_hold || (byte_done && hold_valid_r)) begin
      out_byte_r   <= hold_r;
      out_bv_r     <= 1'b1;
      out_status_r <= ST_OK;
      out_last_r   <= cmd.push_hold && cmd.hold_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

  a_close_format: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bv_r) |-> (out_byte_r == '0 && out_last_r))
    else $error("closing item carries a byte or lacks last");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (pc_r == 3'd0 && pb_r == '0))
    else $error("flush left pending bits");

endmodule

FILE: hdl/rice_encoder_bit_packer_top.sv
// Rice encoder bit packer top level: registers, controller and datapath.
// Items are taken one at a time; ready is high only between items.
// Encode: accept, chunks of up to 8 bits, end of the unary run, end of the
// remainder (k > 0 only), finish, and a closing item after a failure with a held byte.
// Flush: accept, flush, finish; restart and unused codes: accept, finish; stalls add time.
// Synchronous active-low reset clears packer, byte count, rice_k (0), capacity (all ones).
module rice_encoder_bit_packer_top
  import rbp_pkg::*;
#(
  parameter int MAX_QUOTIENT = 255
)
(
  input  logic        clk,
  input  logic        rst_n,
  rbp_in_if.sink      in_ch,
  rbp_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [KW-1:0]   rice_k;
  logic [CAPW-1:0] capacity;
  cmd_t            cmd;
  sts_t            sts;

  rbp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .rice_k      (rice_k),
    .capacity    (capacity)
  );

  rbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd)
  );

  rbp_dp #(
    .MAX_QUOTIENT (MAX_QUOTIENT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .value    (in_ch.value),
    .rice_k   (rice_k),
    .capacity (capacity),
    .out_ch   (out_ch)
  );

endmodule
